@@ rtl/cpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared constants and types for the call profile accumulator.
// ----------------------------------------------------------------------------
package cpa_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int STACK_DEPTH   = 64;
    localparam int TW = $clog2(TABLE_ENTRIES);
    localparam int SW = $clog2(STACK_DEPTH);

    localparam logic [1:0] OP_ENTER = 2'd0;
    localparam logic [1:0] OP_LEAVE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_REC  = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;

    localparam logic [47:0] MAX48 = {48{1'b1}};
    localparam logic [31:0] MAX32 = {32{1'b1}};

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rec_key;
        logic [31:0] call_count;
        logic [31:0] nonrec_count;
        logic [47:0] outer_time;
        logic [47:0] inline_time;
    } result_t;

    typedef struct packed {
        logic [31:0] key;
        logic [47:0] total;
        logic [47:0] inl;
        logic [31:0] calls;
        logic [31:0] reccalls;
        logic [6:0]  level;
    } entry_t;

    function automatic logic [47:0] add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? MAX48 : s[47:0];
    endfunction

    function automatic logic [31:0] inc32(input logic [31:0] a);
        return (a == MAX32) ? a : a + 32'd1;
    endfunction
endpackage

@@ rtl/cpa_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_search
// Serial table scan: one slot a cycle, reports lowest match and lowest free.
// ----------------------------------------------------------------------------
module cpa_search
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          key,
    input  logic [cpa_pkg::TABLE_ENTRIES-1:0] valid,
    input  logic [31:0]          rd_key,
    output logic [cpa_pkg::TW-1:0] rd_addr,
    output logic                 done,
    output logic                 found,
    output logic [cpa_pkg::TW-1:0] hit_idx,
    output logic                 free_ok,
    output logic [cpa_pkg::TW-1:0] free_idx
);
    import cpa_pkg::*;

    logic          busy_reg, chk_reg;
    logic [TW:0]   idx_reg;
    logic [TW-1:0] cidx_reg;

    assign rd_addr = idx_reg[TW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            chk_reg  <= 1'b0;
            done     <= 1'b0;
            found    <= 1'b0;
            free_ok  <= 1'b0;
            idx_reg  <= '0;
            cidx_reg <= '0;
            hit_idx  <= '0;
            free_idx <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                chk_reg  <= 1'b0;
                idx_reg  <= '0;
                found    <= 1'b0;
                free_ok  <= 1'b0;
            end
            else
            begin
                if (busy_reg)
                begin
                    cidx_reg <= idx_reg[TW-1:0];
                    chk_reg  <= 1'b1;
                    if (idx_reg == (TW+1)'(TABLE_ENTRIES - 1))
                        busy_reg <= 1'b0;
                    idx_reg <= idx_reg + 1'b1;
                end
                else
                    chk_reg <= 1'b0;
                if (chk_reg)
                begin
                    if (valid[cidx_reg] && rd_key == key && !found)
                    begin
                        found   <= 1'b1;
                        hit_idx <= cidx_reg;
                    end
                    if (!valid[cidx_reg] && !free_ok)
                    begin
                        free_ok  <= 1'b1;
                        free_idx <= cidx_reg;
                    end
                    if (!busy_reg)
                        done <= 1'b1;
                end
            end
        end
    end
endmodule

@@ rtl/call_profile_accumulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// call_profile_accumulator
// Per-function call profiler with a slot table and an open-call stack.
// Enter and leave run a serial key scan over the slot table; filtered builtin
// events, clear, empty leave and empty flush skip it; a flush closes frames one by one.
// One event in flight; the next input beat is accepted only once the result beat is taken.
// Reset: async active low; clears valid bits, depth, error flag; sets builtins_enable.
// ----------------------------------------------------------------------------
module call_profile_accumulator
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,   // opcode[1:0], func_key[33:2], timestamp[81:34]
    input  logic         s_tuser,   // is_builtin
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // rec_key, call_count, nonrec_count, outer, inline
    output logic [1:0]   m_tuser    // status
);
    import cpa_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_ERD   = 4'd3;
    localparam logic [3:0] S_EWB   = 4'd4;
    localparam logic [3:0] S_LRD   = 4'd5;
    localparam logic [3:0] S_LCALC = 4'd6;
    localparam logic [3:0] S_LWB   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_FRD   = 4'd9;
    localparam logic [3:0] S_FRD2  = 4'd10;
    localparam logic [3:0] S_SCAN0 = 4'd11;
    localparam logic [3:0] S_FWT   = 4'd12;

    entry_t      tab_mem [TABLE_ENTRIES];
    logic [TW-1:0] stk_entry_mem [STACK_DEPTH];
    logic [47:0] stk_start_mem [STACK_DEPTH];
    logic [47:0] stk_sub_mem   [STACK_DEPTH];

    logic [3:0]  state_reg;
    logic        ben_reg, oom_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [SW:0] depth_reg;
    logic [1:0]  op_reg;
    logic [31:0] key_reg;
    logic [47:0] ts_reg;
    logic        is_flush_reg;
    logic [TW-1:0] slot_reg;
    entry_t      ent_reg;
    logic [TW-1:0] tab_raddr;
    logic [TW-1:0] top_ent_reg;
    logic [47:0] top_start_reg, top_sub_reg, par_sub_reg, tt_reg, it_reg;
    result_t     res_reg;
    logic        out_valid_reg;

    logic          srch_start, srch_done, srch_found, srch_free;
    logic [TW-1:0] srch_addr, srch_hit, srch_fidx;
    entry_t        tab_rd;

    cpa_search u_search
    (
        .clk(clk), .rst_n(rst_n), .start(srch_start), .key(key_reg),
        .valid(valid_reg), .rd_key(tab_rd.key), .rd_addr(srch_addr),
        .done(srch_done), .found(srch_found), .hit_idx(srch_hit),
        .free_ok(srch_free), .free_idx(srch_fidx)
    );

    logic          tab_we;
    logic [TW-1:0] tab_waddr;
    entry_t        tab_wdata;
    logic [SW-1:0] top_idx, par_idx;
    logic          stk_we, par_we;
    logic [SW-1:0] stk_widx;

    assign top_idx = depth_reg[SW-1:0] - 1'b1;
    assign par_idx = depth_reg[SW-1:0] - 2'd2;
    assign tab_raddr = (state_reg == S_SCAN || state_reg == S_SCAN0) ? srch_addr : slot_reg;

    always_ff @(posedge clk)
    begin
        tab_rd <= tab_mem[tab_raddr];
        if (tab_we)
            tab_mem[tab_waddr] <= tab_wdata;
        top_ent_reg   <= stk_entry_mem[top_idx];
        top_start_reg <= stk_start_mem[top_idx];
        top_sub_reg   <= stk_sub_mem[top_idx];
        par_sub_reg   <= stk_sub_mem[par_idx];
        if (stk_we)
        begin
            stk_entry_mem[stk_widx] <= slot_reg;
            stk_start_mem[stk_widx] <= ts_reg;
            stk_sub_mem[stk_widx]   <= '0;
        end
        else if (par_we)
            stk_sub_mem[par_idx] <= add48(par_sub_reg, tt_reg);
    end

    assign stk_widx  = depth_reg[SW-1:0];
    assign srch_start = (state_reg == S_DISP) && (op_reg == OP_ENTER || op_reg == OP_LEAVE);

    entry_t upd;
    always_comb
    begin
        upd = ent_reg;
        upd.level = ent_reg.level - 7'd1;
        if (upd.level == 7'd0)
            upd.total = add48(ent_reg.total, tt_reg);
        else
            upd.reccalls = inc32(ent_reg.reccalls);
        upd.inl   = add48(ent_reg.inl, it_reg);
        upd.calls = inc32(ent_reg.calls);
    end

    always_comb
    begin
        tab_we    = 1'b0;
        tab_waddr = slot_reg;
        tab_wdata = ent_reg;
        stk_we    = 1'b0;
        par_we    = 1'b0;
        if (state_reg == S_EWB)
        begin
            tab_we = 1'b1;
            tab_wdata.level = ent_reg.level + 7'd1;
            stk_we = (depth_reg != (SW+1)'(STACK_DEPTH));
            if (!stk_we)
                tab_wdata.level = ent_reg.level;
        end
        if (state_reg == S_LWB)
        begin
            tab_we    = 1'b1;
            tab_wdata = upd;
            par_we    = (depth_reg > (SW+1)'(1));
        end
    end

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {res_reg.inline_time, res_reg.outer_time, res_reg.nonrec_count,
                       res_reg.call_count, res_reg.rec_key};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ben_reg       <= 1'b1;
            oom_reg       <= 1'b0;
            valid_reg     <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
            is_flush_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ben_reg <= cfg_wdata;
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        op_reg  <= s_tdata[1:0];
                        key_reg <= s_tdata[33:2];
                        ts_reg  <= s_tdata[81:34];
                        res_reg <= '0;
                        if ((s_tdata[1:0] == OP_ENTER || s_tdata[1:0] == OP_LEAVE)
                            && s_tuser && !ben_reg)
                            state_reg <= S_OUT;
                        else
                            state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    unique case (op_reg)
                        OP_ENTER: state_reg <= S_SCAN0;
                        OP_LEAVE: state_reg <= (depth_reg == '0) ? S_OUT : S_SCAN0;
                        OP_FLUSH:
                        begin
                            is_flush_reg <= 1'b1;
                            state_reg <= (depth_reg == '0) ? S_OUT : S_FRD;
                        end
                        default:
                        begin
                            valid_reg <= '0;
                            depth_reg <= '0;
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_SCAN0: state_reg <= S_SCAN;
                S_SCAN:
                begin
                    if (srch_done)
                    begin
                        if (op_reg == OP_ENTER)
                        begin
                            if (srch_found)
                            begin
                                slot_reg  <= srch_hit;
                                state_reg <= S_ERD;
                            end
                            else if (srch_free)
                            begin
                                slot_reg <= srch_fidx;
                                valid_reg[srch_fidx] <= 1'b1;
                                ent_reg <= '{key: key_reg, default: '0};
                                state_reg <= S_EWB;
                            end
                            else
                            begin
                                oom_reg   <= 1'b1;
                                state_reg <= S_OUT;
                            end
                        end
                        else if (srch_found)
                        begin
                            slot_reg  <= srch_hit;
                            state_reg <= S_LRD;
                        end
                        else
                        begin
                            depth_reg <= depth_reg - 1'b1;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_ERD:
                begin
                    ent_reg   <= tab_rd;
                    state_reg <= (slot_reg == tab_raddr) ? S_FRD2 : S_ERD;
                end
                S_FRD2:
                begin
                    if (op_reg == OP_ENTER)
                    begin
                        ent_reg   <= tab_rd;
                        state_reg <= S_EWB;
                    end
                    else
                    begin
                        ent_reg   <= tab_rd;
                        state_reg <= S_LCALC;
                    end
                end
                S_EWB:
                begin
                    if (depth_reg == (SW+1)'(STACK_DEPTH))
                        oom_reg <= 1'b1;
                    else
                        depth_reg <= depth_reg + 1'b1;
                    state_reg <= S_OUT;
                end
                S_FWT: state_reg <= S_FRD;
                S_FRD:
                begin
                    slot_reg  <= top_ent_reg;
                    state_reg <= S_LRD;
                end
                S_LRD: state_reg <= S_FRD2;
                S_LCALC:
                begin
                    tt_reg <= ts_reg - top_start_reg;
                    it_reg <= ((ts_reg - top_start_reg) >= top_sub_reg)
                              ? (ts_reg - top_start_reg) - top_sub_reg : '0;
                    state_reg <= S_LWB;
                end
                S_LWB:
                begin
                    depth_reg <= depth_reg - 1'b1;
                    if (is_flush_reg)
                        state_reg <= (depth_reg == (SW+1)'(1)) ? S_OUT : S_FWT;
                    else
                    begin
                        if (oom_reg)
                        begin
                            oom_reg <= 1'b0;
                            res_reg.status <= ST_OOM;
                        end
                        else
                        begin
                            res_reg.status       <= ST_REC;
                            res_reg.rec_key      <= upd.key;
                            res_reg.call_count   <= upd.calls;
                            res_reg.nonrec_count <= (upd.calls >= upd.reccalls)
                                                    ? upd.calls - upd.reccalls : '0;
                            res_reg.outer_time   <= upd.total;
                            res_reg.inline_time  <= upd.inl;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        is_flush_reg  <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ tb/tb_call_profile_accumulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_call_profile_accumulator
// Self-checking bench for the call profile accumulator. Timestamped enter,
// leave, flush and clear beats are fed through the input stream and checked
// against a behavioral profile of the slot table and call stack. The run has
// a directed table, exhaustion runs for the slot table and the stack, and
// random nested call traffic under both builtin filter settings. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module tb_call_profile_accumulator;
    import cpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 210;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic         cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [87:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [1:0]   m_tuser;

    call_profile_accumulator uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // profile state
    logic [31:0] slot_key     [TABLE_ENTRIES];
    bit          slot_valid   [TABLE_ENTRIES];
    logic [47:0] slot_total   [TABLE_ENTRIES];
    logic [47:0] slot_inline  [TABLE_ENTRIES];
    logic [31:0] slot_calls   [TABLE_ENTRIES];
    logic [31:0] slot_rec     [TABLE_ENTRIES];
    logic [6:0]  slot_level   [TABLE_ENTRIES];
    int          frame_slot   [STACK_DEPTH];
    logic [47:0] frame_start  [STACK_DEPTH];
    logic [47:0] frame_sub    [STACK_DEPTH];
    int          open_depth;
    bit          oom_pending;
    bit          builtin_on;

    result_t     expected_results[$];
    int          fail_count;
    int          beat_count;
    int          record_count;
    int          oom_count;
    bit          idle_on;
    int          hold_reqs;
    int          hold_seen;
    int          hold_left;
    int          quiet_cycles;
    logic [47:0] clock_ts;
    logic [31:0] key_pool[10];

    typedef struct {
        logic [1:0]  op;
        logic [31:0] key;
        bit          bi;
        logic [47:0] ts;
        bit          has_exp;
        result_t     exp;
    } vector_t;

    function automatic logic [47:0] sat_add48(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? MAX48 : s[47:0];
    endfunction

    function automatic logic [31:0] sat_inc32(logic [31:0] a);
        return (a == MAX32) ? a : a + 32'd1;
    endfunction

    function automatic int lookup_slot(logic [31:0] key);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_valid[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic void close_frame(int e, logic [47:0] ts);
        int          d;
        logic [47:0] elapsed;
        logic [47:0] inl;
        d = open_depth - 1;
        elapsed = ts - frame_start[d];
        inl = (elapsed >= frame_sub[d]) ? elapsed - frame_sub[d] : 48'd0;
        if (d > 0)
            frame_sub[d-1] = sat_add48(frame_sub[d-1], elapsed);
        open_depth = d;
        slot_level[e] = slot_level[e] - 7'd1;
        if (slot_level[e] == 7'd0)
            slot_total[e] = sat_add48(slot_total[e], elapsed);
        else
            slot_rec[e] = sat_inc32(slot_rec[e]);
        slot_inline[e] = sat_add48(slot_inline[e], inl);
        slot_calls[e] = sat_inc32(slot_calls[e]);
    endfunction

    function automatic result_t profile_event(logic [1:0] op, logic [31:0] key, bit bi,
                                              logic [47:0] ts);
        result_t r;
        int      s;
        r = '0;
        r.status = ST_NONE;
        if ((op == OP_ENTER || op == OP_LEAVE) && bi && !builtin_on)
            return r;
        case (op)
            OP_ENTER:
            begin
                s = lookup_slot(key);
                if (s < 0)
                begin
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (!slot_valid[i])
                        begin
                            s = i;
                            break;
                        end
                    if (s < 0)
                    begin
                        oom_pending = 1;
                        return r;
                    end
                    slot_valid[s]  = 1;
                    slot_key[s]    = key;
                    slot_total[s]  = '0;
                    slot_inline[s] = '0;
                    slot_calls[s]  = '0;
                    slot_rec[s]    = '0;
                    slot_level[s]  = '0;
                end
                if (open_depth >= STACK_DEPTH)
                begin
                    oom_pending = 1;
                    return r;
                end
                slot_level[s] = slot_level[s] + 7'd1;
                frame_slot[open_depth]  = s;
                frame_start[open_depth] = ts;
                frame_sub[open_depth]   = '0;
                open_depth++;
            end
            OP_LEAVE:
            begin
                if (open_depth == 0)
                    return r;
                s = lookup_slot(key);
                if (s < 0)
                begin
                    open_depth--;
                    return r;
                end
                close_frame(s, ts);
                if (oom_pending)
                begin
                    oom_pending = 0;
                    r.status = ST_OOM;
                    return r;
                end
                r.status       = ST_REC;
                r.rec_key      = slot_key[s];
                r.call_count   = slot_calls[s];
                r.nonrec_count = (slot_calls[s] >= slot_rec[s]) ? slot_calls[s] - slot_rec[s] : '0;
                r.outer_time   = slot_total[s];
                r.inline_time  = slot_inline[s];
            end
            OP_FLUSH:
                while (open_depth > 0)
                    close_frame(frame_slot[open_depth-1], ts);
            default:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    slot_valid[i] = 0;
                open_depth = 0;
            end
        endcase
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // send one event beat; typed expectation overrides the profile result
    task automatic send_event(logic [1:0] op, logic [31:0] key, bit bi, logic [47:0] ts,
                              bit has_exp = 0, result_t exp = '0);
        result_t r;
        if (idle_on && $urandom_range(0, 99) < 18)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, ts, key, op};
        s_tuser  <= bi;
        do @(posedge clk); while (!s_tready);
        r = profile_event(op, key, bi, ts);
        expected_results.push_back(has_exp ? exp : r);
        beat_count++;
    endtask

    task automatic drain_results();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TABLE_ENTRIES + 16) @(posedge clk);
    endtask

    task automatic write_builtin_enable(bit v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        builtin_on = v;
    endtask

    function automatic logic [47:0] next_ts();
        if ($urandom_range(0, 99) < 3)
            clock_ts = 48'({$urandom, $urandom});
        else if ($urandom_range(0, 99) < 2)
            clock_ts = clock_ts + {$urandom_range(32'h7fff, 32'hffff), 16'h0};
        else
            clock_ts = clock_ts + $urandom_range(1, 1000);
        return clock_ts;
    endfunction

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 99) < 6)
            return $urandom;
        return key_pool[$urandom_range(0, 9)];
    endfunction

    task automatic random_event();
        int          roll;
        logic [31:0] key;
        logic [47:0] ts;
        bit          bi;
        roll = $urandom_range(0, 999);
        ts   = next_ts();
        bi   = ($urandom_range(0, 99) < 15);
        if (roll < 8)
            send_event(OP_CLEAR, $urandom, bi, ts);
        else if (roll < 25)
            send_event(OP_FLUSH, $urandom, bi, ts);
        else if (roll < 70)
            send_event(OP_LEAVE, pick_key(), bi, ts);
        else if (open_depth > 0 && roll < (open_depth > 8 ? 700 : 480))
        begin
            key = slot_key[frame_slot[open_depth-1]];
            send_event(OP_LEAVE, key, bi, ts);
        end
        else
            send_event(OP_ENTER, pick_key(), bi, ts);
    endtask

    vector_t directed[$];

    function automatic result_t rec(logic [31:0] k, logic [31:0] c, logic [31:0] n,
                                    logic [47:0] t, logic [47:0] i);
        result_t r;
        r = '{ST_REC, k, c, n, t, i};
        return r;
    endfunction

    initial
    begin
        result_t none;
        result_t oom;
        none = '0;
        oom  = '0;
        oom.status = ST_OOM;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        fail_count = 0;
        beat_count = 0;
        record_count = 0;
        oom_count  = 0;
        hold_reqs  = 0;
        idle_on    = 1;
        clock_ts   = '0;
        open_depth = 0;
        oom_pending = 0;
        builtin_on = 1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            slot_valid[i] = 0;
        for (int i = 0; i < 10; i++)
            key_pool[i] = $urandom;

        directed = '{
            '{OP_LEAVE, 32'd5,        0, 48'd10,  1, none},
            '{OP_ENTER, 32'd0,        0, 48'd0,   1, none},
            '{OP_ENTER, 32'hffffffff, 1, MAX48,   1, none},
            '{OP_LEAVE, 32'hffffffff, 1, 48'd5,   1, rec(32'hffffffff, 1, 1, 6, 6)},
            '{OP_LEAVE, 32'd0,        0, 48'd100, 1, rec(32'd0, 1, 1, 100, 94)},
            '{OP_ENTER, 32'd7,        0, 48'd200, 0, none},
            '{OP_ENTER, 32'd7,        0, 48'd300, 0, none},
            '{OP_ENTER, 32'd9,        0, 48'd310, 0, none},
            '{OP_LEAVE, 32'd7,        0, 48'd320, 0, none},
            '{OP_LEAVE, 32'd7,        0, 48'd350, 0, none},
            '{OP_LEAVE, 32'd7,        0, 48'd400, 0, none},
            '{OP_ENTER, 32'd3,        0, 48'd500, 1, none},
            '{OP_LEAVE, 32'd1234,     0, 48'd510, 1, none},
            '{OP_ENTER, 32'd3,        0, 48'd600, 1, none},
            '{OP_ENTER, 32'd4,        1, 48'd650, 1, none},
            '{OP_ENTER, 32'd3,        0, 48'd660, 1, none},
            '{OP_FLUSH, 32'd0,        0, 48'd700, 1, none},
            '{OP_LEAVE, 32'd3,        0, 48'd710, 1, none},
            '{OP_ENTER, 32'd8,        0, 48'd0,   1, none},
            '{OP_LEAVE, 32'd8,        0, MAX48 - 48'd1, 0, none},
            '{OP_ENTER, 32'd8,        0, 48'd0,   1, none},
            '{OP_LEAVE, 32'd8,        0, MAX48 - 48'd1, 0, none},
            '{OP_CLEAR, 32'hffffffff, 1, MAX48,   1, none},
            '{OP_LEAVE, 32'd8,        0, 48'd20,  1, none}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_event(directed[i].op, directed[i].key, directed[i].bi, directed[i].ts,
                       directed[i].has_exp, directed[i].exp);

        // builtins disabled: builtin events are filtered out
        write_builtin_enable(0);
        send_event(OP_ENTER, 32'd11, 0, 48'd10, 1, none);
        send_event(OP_ENTER, 32'd12, 1, 48'd20, 1, none);
        send_event(OP_LEAVE, 32'd11, 1, 48'd30, 1, none);
        send_event(OP_LEAVE, 32'd11, 0, 48'd40, 1, rec(32'd11, 1, 1, 30, 30));
        write_builtin_enable(1);

        // stack exhaustion, slot for the new key is kept
        send_event(OP_CLEAR, 32'd0, 0, 48'd0);
        for (int i = 0; i < STACK_DEPTH; i++)
            send_event(OP_ENTER, 32'd21, 0, next_ts());
        send_event(OP_ENTER, 32'd22, 0, next_ts(), 1, none);
        send_event(OP_LEAVE, 32'd21, 0, next_ts(), 1, oom);
        send_event(OP_LEAVE, 32'd22, 0, next_ts());
        send_event(OP_FLUSH, 32'd0, 0, next_ts(), 1, none);

        // slot table exhaustion
        send_event(OP_CLEAR, 32'd0, 0, 48'd0);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            send_event(OP_ENTER, 32'h100 + i, 0, next_ts());
            send_event(OP_LEAVE, 32'h100 + i, 0, next_ts());
        end
        send_event(OP_ENTER, 32'h5000, 0, next_ts(), 1, none);
        send_event(OP_ENTER, 32'h100, 0, next_ts());
        send_event(OP_LEAVE, 32'h100, 0, next_ts(), 1, oom);
        send_event(OP_CLEAR, 32'd0, 0, next_ts(), 1, none);

        // output back-pressure while the sender keeps offering
        hold_reqs++;
        for (int i = 0; i < 12; i++)
            random_event();
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_on = !(i >= 20 && i < 80);
            if (i == 100)
                write_builtin_enable(0);
            if (i == 160)
                write_builtin_enable(1);
            random_event();
        end

        drain_results();
        $display("Covered %0d event beats: %0d records, %0d out-of-memory reports,",
                 beat_count, record_count, oom_count);
        $display("both builtin filter settings, table and stack exhaustion, back-pressure.");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // result side: ready pattern and checking
    initial
    begin
        m_tready  = 1'b0;
        hold_seen = 0;
        hold_left = 0;
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t exp;
        if (m_tvalid && m_tready)
        begin
            got.status       = m_tuser;
            got.rec_key      = m_tdata[31:0];
            got.call_count   = m_tdata[63:32];
            got.nonrec_count = m_tdata[95:64];
            got.outer_time   = m_tdata[143:96];
            got.inline_time  = m_tdata[191:144];
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                exp = expected_results.pop_front();
                if (got.status == ST_REC)
                    record_count++;
                if (got.status == ST_OOM)
                    oom_count++;
                if (got.status !== exp.status)
                    $error("status exp %0d got %0d", exp.status, got.status);
                if (got.rec_key !== exp.rec_key)
                    $error("rec_key exp %h got %h", exp.rec_key, got.rec_key);
                if (got.call_count !== exp.call_count)
                    $error("call_count exp %0d got %0d", exp.call_count, got.call_count);
                if (got.nonrec_count !== exp.nonrec_count)
                    $error("nonrec_count exp %0d got %0d", exp.nonrec_count, got.nonrec_count);
                if (got.outer_time !== exp.outer_time)
                    $error("outer_time exp %0d got %0d", exp.outer_time, got.outer_time);
                if (got.inline_time !== exp.inline_time)
                    $error("inline_time exp %0d got %0d", exp.inline_time, got.inline_time);
                if (got !== exp)
                    fail_count++;
            end
        end
        if (hold_reqs != hold_seen)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= !(idle_on && $urandom_range(0, 99) < 18);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
        quiet_cycles = 0;

endmodule
